// File: rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
package lkvc_pkg;

    localparam int unsigned ENTRIES_DEFAULT = 16;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CAP_W   = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request: operation, key, value packed from bit 0, padded to whole bytes
    localparam int unsigned S_TDATA_W = 72;
    // result: found, read value packed from bit 0, padded to whole bytes
    localparam int unsigned M_TDATA_W = 40;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-3:0] REG_CAPACITY = '0;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic is_get;
    } t_status;

endpackage

// File: rtl/lkvc_ctrl.sv
`timescale 1ns / 1ps
module lkvc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_m_tready,
    input  lkvc_pkg::t_status i_status,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    output lkvc_pkg::t_cmd    o_cmd
);
    import lkvc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_s_tready;
    logic   r_m_tvalid;
    logic   w_go;

    // hold a get while the previous result still waits in the output register
    assign w_go = !(i_status.is_get && r_m_tvalid && !i_m_tready);

    assign o_cmd.capture = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.exec    = (r_state == S_EXEC) && w_go;

    assign o_s_tready = r_s_tready;
    assign o_m_tvalid = r_m_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_s_tready <= 1'b1;
            r_m_tvalid <= 1'b0;
        end else begin
            // a new result takes the output register even as the old one leaves
            if (o_cmd.exec && i_status.is_get) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state    <= S_EXEC;
                        r_s_tready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (w_go) begin
                        r_state    <= S_IDLE;
                        r_s_tready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_s_tready <= 1'b1;
                end
            endcase
        end
    end

endmodule

// File: rtl/lkvc_dpath.sv
`timescale 1ns / 1ps
module lkvc_dpath #(
    parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lkvc_pkg::t_cmd               i_cmd,
    input  logic                         i_op,
    input  logic [lkvc_pkg::KEY_W-1:0]   i_key,
    input  logic [lkvc_pkg::VALUE_W-1:0] i_value,
    input  logic [lkvc_pkg::CAP_W-1:0]   i_capacity,
    output lkvc_pkg::t_status            o_status,
    output logic                         o_found,
    output logic [lkvc_pkg::VALUE_W-1:0] o_read_value
);
    import lkvc_pkg::*;

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // captured request
    logic               r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_value;
    logic [ENTRIES-1:0] r_hit;

    // store
    logic [ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_rank [ENTRIES];
    logic [KEY_W-1:0]   r_keys [ENTRIES];
    logic [CNT_W-1:0]   r_fill;
    logic [VALUE_W-1:0] r_mem  [ENTRIES];

    // result
    logic               r_found;
    logic [VALUE_W-1:0] r_rd_data;

    logic               w_hit_any;
    logic               w_is_put;
    logic [ENTRIES-1:0] w_free;
    logic [ENTRIES-1:0] w_victim;
    logic [ENTRIES-1:0] w_target;
    logic [IDX_W-1:0]   w_last_rank;
    logic [IDX_W-1:0]   w_target_rank;
    logic [IDX_W-1:0]   w_target_idx;
    logic [CMP_W-1:0]   w_cap;
    logic               w_room;
    logic               w_fill_mode;
    logic               w_update;

    assign w_hit_any   = |r_hit;
    assign w_is_put    = (r_op == OP_PUT);
    assign w_last_rank = IDX_W'(r_fill - CNT_W'(1));

    // lowest free slot
    always_comb begin
        w_free = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free    = '0;
                w_free[i] = 1'b1;
            end
        end
    end

    // ranks of valid entries run 0 .. fill-1, so the oldest is rank fill-1
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_victim[i] = r_valid[i] && (r_rank[i] == w_last_rank);
        end
    end

    always_comb begin
        w_cap = CMP_W'(i_capacity);
        if (w_cap == '0) begin
            w_cap = CMP_W'(1);
        end
        if (w_cap > CMP_W'(ENTRIES)) begin
            w_cap = CMP_W'(ENTRIES);
        end
    end

    assign w_room      = CMP_W'(r_fill) < w_cap;
    assign w_fill_mode = !w_hit_any && w_room;
    assign w_target    = w_hit_any ? r_hit : (w_room ? w_free : w_victim);
    assign w_update    = i_cmd.exec && (w_is_put || w_hit_any);

    always_comb begin
        w_target_rank = '0;
        w_target_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_target[i]) begin
                w_target_rank = w_target_rank | r_rank[i];
                w_target_idx  = w_target_idx | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (w_update) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (w_target[i]) begin
                    r_rank[i]  <= '0;
                    r_valid[i] <= 1'b1;
                end else if (r_valid[i] && (w_fill_mode || r_rank[i] < w_target_rank)) begin
                    r_rank[i] <= r_rank[i] + IDX_W'(1);
                end
            end
            if (w_fill_mode) begin
                r_fill <= r_fill + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
            for (int i = 0; i < ENTRIES; i++) begin
                r_hit[i] <= r_valid[i] && (r_keys[i] == i_key);
            end
        end
        if (i_cmd.exec && w_is_put) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (w_target[i]) begin
                    r_keys[i] <= r_key;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (w_is_put) begin
                r_mem[w_target_idx] <= r_value;
            end else begin
                r_rd_data <= r_mem[w_target_idx];
                r_found   <= w_hit_any;
            end
        end
    end

    assign o_status.is_get = (r_op == OP_GET);
    assign o_found         = r_found;
    assign o_read_value    = r_found ? r_rd_data : MISS_VALUE;

endmodule

// File: rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// A get's result is valid on m_axis once its key compare and value-store read are done.
// One request is in flight at a time; the key compare is registered at capture, then the
// rank update and the registered value-store read or write follow in the execute state.
// A get waits in the execute state while the previous result is still untaken.
// Reset (synchronous, active low) empties the store and sets capacity_in_use to 16.
module lru_key_value_cache #(
    parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] operation, [32:1] lookup_key, [64:33] write_value
    input  logic [lkvc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] found, [32:1] read_value
    output logic [lkvc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkvc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [lkvc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [lkvc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import lkvc_pkg::*;

    logic [CAP_W-1:0]   r_capacity;
    logic               w_cap_sel;
    t_cmd               w_cmd;
    t_status            w_status;
    logic               w_found;
    logic [VALUE_W-1:0] w_read_value;

    assign pready    = 1'b1;
    assign w_cap_sel = (paddr[CFG_ADDR_W-1:2] == REG_CAPACITY);
    assign prdata    = w_cap_sel ? CFG_DATA_W'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && w_cap_sel) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    lkvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (w_status),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    lkvc_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_op         (s_axis_tdata[0]),
        .i_key        (s_axis_tdata[KEY_W:1]),
        .i_value      (s_axis_tdata[KEY_W+VALUE_W:KEY_W+1]),
        .i_capacity   (r_capacity),
        .o_status     (w_status),
        .o_found      (w_found),
        .o_read_value (w_read_value)
    );

    assign m_axis_tdata = {{(M_TDATA_W - VALUE_W - 1){1'b0}}, w_read_value, w_found};

    // one request in flight: ready drops after every accepted request
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // a get met with an empty output register is answered without being held
    a_get_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] == OP_GET) && !m_axis_tvalid
        |=> ##1 m_axis_tvalid)
        else $error("get not answered in time");

    // a put met with an empty output register gives no result
    a_put_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] == OP_PUT) && !m_axis_tvalid
        |=> !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("put produced a result");

    // a miss carries the all-ones value
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[VALUE_W:1] == MISS_VALUE))
        else $error("miss result without all-ones value");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import lkvc_pkg::*;

    localparam int unsigned SLOTS         = ENTRIES_DEFAULT;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned MAX_REPORTS   = 40;
    localparam int unsigned POOL_MAX      = 32;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] value;
    } t_read_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [0] operation, [32:1] lookup_key, [64:33] write_value
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] found, [32:1] read_value
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of the cache contents
    logic [KEY_W-1:0]   slot_key   [SLOTS] = '{default: '0};
    logic [VALUE_W-1:0] slot_value [SLOTS] = '{default: '0};
    logic               slot_valid [SLOTS] = '{default: 1'b0};
    int unsigned        slot_rank  [SLOTS] = '{default: 0};
    int unsigned        fill_count = 0;
    logic [CAP_W-1:0]   capacity_setting = CAP_RESET;

    t_read_result pending_reads [$];
    logic [KEY_W-1:0] key_pool [POOL_MAX];
    int unsigned pool_size = 1;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned get_count = 0;
    int unsigned put_count = 0;
    int unsigned hit_count = 0;
    int unsigned miss_count = 0;
    int unsigned cycle_count = 0;

    lru_key_value_cache dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lru_key_value_cache: mismatch");
            $finish;
        end
    end

    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Move slot s to the front; valid entries that were newer slip back one place
    function automatic void make_newest(input int s);
        int unsigned r;
        r = slot_rank[s];
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && i != s && slot_rank[i] < r)
                slot_rank[i]++;
        end
        slot_rank[s] = 0;
    endfunction

    function automatic void predict_cache_access(input logic op, input logic [KEY_W-1:0] key,
                                                 input logic [VALUE_W-1:0] val);
        int hit_slot;
        int target;
        int unsigned limit;
        t_read_result res;
        hit_slot = find_slot(key);
        if (op == OP_GET) begin
            get_count++;
            if (hit_slot >= 0) begin
                make_newest(hit_slot);
                res.found = 1'b1;
                res.value = slot_value[hit_slot];
                hit_count++;
            end else begin
                res.found = 1'b0;
                res.value = MISS_VALUE;
                miss_count++;
            end
            pending_reads.push_back(res);
            return;
        end
        put_count++;
        if (hit_slot >= 0) begin
            slot_value[hit_slot] = val;
            make_newest(hit_slot);
            return;
        end
        limit = (capacity_setting == 0) ? 1 : capacity_setting;
        if (limit > SLOTS)
            limit = SLOTS;
        target = -1;
        if (fill_count < limit) begin
            // take the lowest free slot, everything else ages by one
            for (int i = 0; i < SLOTS; i++) begin
                if (!slot_valid[i] && target < 0)
                    target = i;
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_valid[i])
                    slot_rank[i]++;
            end
            slot_valid[target] = 1'b1;
            slot_key[target] = key;
            slot_value[target] = val;
            slot_rank[target] = 0;
            fill_count++;
        end else begin
            // replace the least recent entry; the count stays put
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_valid[i] && (target < 0 || slot_rank[i] > slot_rank[target]))
                    target = i;
            end
            slot_key[target] = key;
            slot_value[target] = val;
            make_newest(target);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_read_result want;
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_reads.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $error("result with no get pending: found %0b read_value %h",
                           m_axis_tdata[0], m_axis_tdata[VALUE_W:1]);
                error_count++;
            end else begin
                want = pending_reads.pop_front();
                if (m_axis_tdata[0] !== want.found) begin
                    if (error_count < MAX_REPORTS)
                        $error("found: expected %0b, got %0b", want.found, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[VALUE_W:1] !== want.value) begin
                    if (error_count < MAX_REPORTS)
                        $error("read_value: expected %h, got %h", want.value,
                               m_axis_tdata[VALUE_W:1]);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] val);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[0] = op;
        word[KEY_W:1] = key;
        word[KEY_W+VALUE_W:KEY_W+1] = val;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_cache_access(op, key, val);
    endtask

    // Hold the sender until every get is answered, then let a trailing put finish
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        logic [CFG_ADDR_W-1:0] addr;
        addr = {REG_CAPACITY, 2'b00};
        wait_results_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= CFG_DATA_W'(cap);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        capacity_setting = cap;
        // read back straight after the write
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[CAP_W-1:0] !== cap) begin
            $error("capacity_in_use: expected %0d, got %0d", cap, prdata[CAP_W-1:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void refill_key_pool(input int unsigned n);
        pool_size = n;
        for (int i = 0; i < POOL_MAX; i++)
            key_pool[i] = $urandom();
    endfunction

    // Mostly keys from the pool so hits and refreshes are common; some near misses and strays
    task automatic send_random_requests(input int unsigned n);
        int unsigned roll;
        logic op;
        logic [KEY_W-1:0] key;
        for (int unsigned k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            op = ($urandom_range(99) < 45) ? OP_PUT : OP_GET;
            if (roll < 80)
                key = key_pool[$urandom_range(pool_size - 1)];
            else if (roll < 90)
                key = key_pool[$urandom_range(pool_size - 1)] ^ (32'h1 << $urandom_range(31));
            else
                key = $urandom();
            send_request(op, key, $urandom());
        end
    endtask

    task automatic test_empty_misses();
        send_request(OP_GET, 32'h0000_0000, 32'h0);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
    endtask

    task automatic test_single_entry();
        set_capacity(5'd1);
        send_request(OP_PUT, 32'h0000_0001, 32'h1111_1111);
        send_request(OP_PUT, 32'h0000_0002, 32'h2222_2222);
        send_request(OP_GET, 32'h0000_0001, 32'h0);
        send_request(OP_GET, 32'h0000_0002, 32'h0);
    endtask

    task automatic test_extreme_fields();
        set_capacity(5'd3);
        send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
        send_request(OP_GET, 32'h8000_0000, 32'h0);
        send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
    endtask

    task automatic test_refresh_and_evict();
        send_request(OP_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
        send_request(OP_GET, 32'h8000_0000, 32'h0);
        send_request(OP_PUT, 32'h1234_5678, 32'hA5A5_A5A5);
        send_request(OP_GET, 32'h0000_0000, 32'h0);
        send_request(OP_GET, 32'h8000_0000, 32'h0);
    endtask

    // Capacity below the number held: new keys must evict rather than shrink the store
    task automatic test_shrink_capacity();
        set_capacity(5'd2);
        send_request(OP_PUT, 32'hCAFE_0001, 32'h0BAD_F00D);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_GET, 32'hCAFE_0001, 32'h0);
    endtask

    task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int unsigned send_pct,
                                       input int unsigned recv_pct, input int unsigned pool_n,
                                       input int unsigned n);
        set_capacity(cap);
        refill_key_pool(pool_n);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        send_random_requests(n);
    endtask

    task automatic test_pause_for_results();
        set_capacity(5'd14);
        refill_key_pool(18);
        send_idle_pct  = 23;
        recv_stall_pct = 23;
        send_random_requests(20);
        wait_results_drained();
        send_random_requests(20);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_misses();
        test_single_entry();
        test_extreme_fields();
        test_refresh_and_evict();
        test_shrink_capacity();

        test_random_traffic(5'd4,  0,  0,  8,  130);
        test_random_traffic(5'd7,  53, 0,  10, 130);
        test_random_traffic(5'd9,  0,  53, 12, 130);
        test_random_traffic(5'd12, 23, 23, 16, 130);
        test_pause_for_results();
        test_random_traffic(5'd15, 0,  0,  20, 130);
        test_random_traffic(5'd16, 53, 0,  24, 130);
        test_random_traffic(5'd16, 0,  53, 24, 130);
        test_random_traffic(5'd16, 23, 23, 24, 130);

        wait_results_drained();
        $display("Covered %0d requests: %0d gets (%0d hits, %0d misses) and %0d puts.",
                 get_count + put_count, get_count, hit_count, miss_count, put_count);
        $display("Capacity swept from 1 to 16 and cut below the fill level, under four stall mixes.");
        if (error_count == 0) begin
            $display("lru_key_value_cache: match");
        end else begin
            $display("lru_key_value_cache: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/lkvc_pkg.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_dpath.sv
rtl/lru_key_value_cache.sv
verif/tb_top.sv
